// ----- rtl/core/assert_macros.svh -----
// Assertion macros shared by the RTL that checks itself.
// No dependencies; the including module must have clk and rst_n in scope.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property on every rising clock edge, ignored while reset is held.
`define ASSERT_CLK(label, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Check an implication on every rising clock edge, ignored while reset is held.
`define ASSERT_IMPL(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

`endif

// ----- rtl/core/c8alu_pkg.sv -----
// Shared types and operation codes for the 8-bit ALU pipeline.
// No dependencies; used by c8alu_exec and cpu8_alu_with_bcd_flags.
package c8alu_pkg;

    // Operation codes
    localparam logic [4:0] MODE_ADD   = 5'd0;
    localparam logic [4:0] MODE_ADC   = 5'd1;
    localparam logic [4:0] MODE_SUB   = 5'd2;
    localparam logic [4:0] MODE_SBB   = 5'd3;
    localparam logic [4:0] MODE_AND   = 5'd4;
    localparam logic [4:0] MODE_XOR   = 5'd5;
    localparam logic [4:0] MODE_OR    = 5'd6;
    localparam logic [4:0] MODE_CMP   = 5'd7;
    localparam logic [4:0] MODE_INC   = 5'd8;
    localparam logic [4:0] MODE_DEC   = 5'd9;
    localparam logic [4:0] MODE_DAA   = 5'd10;
    localparam logic [4:0] MODE_RLC   = 5'd11;
    localparam logic [4:0] MODE_RRC   = 5'd12;
    localparam logic [4:0] MODE_RAL   = 5'd13;
    localparam logic [4:0] MODE_RAR   = 5'd14;
    localparam logic [4:0] MODE_CMA   = 5'd15;
    localparam logic [4:0] MODE_STC   = 5'd16;
    localparam logic [4:0] MODE_CMC   = 5'd17;
    localparam logic [4:0] MODE_ADD16 = 5'd18;

    // Decimal adjust constants
    localparam logic [7:0] DAA_LO_CORR = 8'h06;
    localparam logic [7:0] DAA_HI_CORR = 8'h60;
    localparam logic [3:0] BCD_MAX     = 4'd9;

    // Five processor flags
    typedef struct packed {
        logic sign;
        logic zero;
        logic aux;
        logic parity;
        logic carry;
    } flags_t;

    // One operation as it enters the pipeline
    typedef struct packed {
        logic [4:0]  mode;
        logic [7:0]  acc;
        logic [7:0]  operand;
        logic [15:0] pair_base;
        logic [15:0] pair_addend;
        flags_t      flags;
    } op_t;

    // Execute stage result; sign, zero and parity are finished in the last stage
    typedef struct packed {
        logic [7:0]  result;
        logic [15:0] pair_sum;
        logic        write_back;
        logic        szp_upd;
        flags_t      flags;
    } exec_t;

endpackage

// ----- rtl/core/cpu8_alu_with_bcd_flags.sv -----
// Channel   Dir  Width (data/user)  Contents
// s_*       in   56 / 5            operation: operands, pair, flags / mode
// m_*       out  32 / 1            result, pair sum, new flags / write-back mark
//
// Three register stages: input capture, execute, flag finish and output.
// An input transfer is registered in the input capture, execute and flag finish
// stages in turn before it can transfer out. One item per cycle while m_tready does not stall.
// Each stage advances when its successor is empty or advancing, so a stall on
// m_tready holds every item in place. rst_n clears the valid bits only.
//
// Top level of the 8-bit ALU pipeline. Depends on c8alu_pkg, c8alu_exec and
// assert_macros.svh.
module cpu8_alu_with_bcd_flags (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    // acc[7:0], operand[15:8], pair_base[31:16], pair_addend[47:32],
    // sign_in[48], zero_in[49], aux_in[50], parity_in[51], carry_in[52], zero pad
    input  logic [55:0] s_tdata,
    // mode[4:0]
    input  logic [4:0]  s_tuser,
    output logic        m_tvalid,
    input  logic        m_tready,
    // result[7:0], pair_sum[23:8], sign_out[24], zero_out[25], aux_out[26],
    // parity_out[27], carry_out[28], zero pad
    output logic [31:0] m_tdata,
    // write_back[0]
    output logic        m_tuser
);
    import c8alu_pkg::*;

    logic   v1_reg, v2_reg, v3_reg;
    logic   rdy1, rdy2, rdy3;
    op_t    op_next, op_reg;
    exec_t  ex_next, ex_reg;
    logic [7:0]  res3_reg, res3_next;
    logic [15:0] psum3_reg, psum3_next;
    logic        wb3_reg, wb3_next;
    flags_t      flg3_reg, flg3_next;

    // Ready chain: a stage takes data when empty or when it moves on
    assign rdy3     = ~v3_reg | m_tready;
    assign rdy2     = ~v2_reg | rdy3;
    assign rdy1     = ~v1_reg | rdy2;
    assign s_tready = rdy1;

    // Unpack the input transfer
    always_comb
    begin
        op_next.mode         = s_tuser;
        op_next.acc          = s_tdata[7:0];
        op_next.operand      = s_tdata[15:8];
        op_next.pair_base    = s_tdata[31:16];
        op_next.pair_addend  = s_tdata[47:32];
        op_next.flags.sign   = s_tdata[48];
        op_next.flags.zero   = s_tdata[49];
        op_next.flags.aux    = s_tdata[50];
        op_next.flags.parity = s_tdata[51];
        op_next.flags.carry  = s_tdata[52];
    end

    c8alu_exec u_exec (
        .op (op_reg),
        .ex (ex_next)
    );

    // Finish sign, zero and parity from the result
    always_comb
    begin
        res3_next  = ex_reg.result;
        psum3_next = ex_reg.pair_sum;
        wb3_next   = ex_reg.write_back;
        flg3_next  = ex_reg.flags;
        if (ex_reg.szp_upd)
        begin
            flg3_next.sign   = ex_reg.result[7];
            flg3_next.zero   = (ex_reg.result == 8'h00);
            flg3_next.parity = ~^ex_reg.result;
        end
    end

    // Advance valid bits
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
        end
        else
        begin
            if (rdy1)
                v1_reg <= s_tvalid;
            if (rdy2)
                v2_reg <= v1_reg;
            if (rdy3)
                v3_reg <= v2_reg;
        end
    end

    // Advance payload, hold on stall
    always_ff @(posedge clk)
    begin
        if (rdy1 && s_tvalid)
            op_reg <= op_next;
        if (rdy2 && v1_reg)
            ex_reg <= ex_next;
        if (rdy3 && v2_reg)
        begin
            res3_reg  <= res3_next;
            psum3_reg <= psum3_next;
            wb3_reg   <= wb3_next;
            flg3_reg  <= flg3_next;
        end
    end

    // Pack the output transfer
    assign m_tvalid = v3_reg;
    assign m_tuser  = wb3_reg;
    assign m_tdata  = {3'b000, flg3_reg.carry, flg3_reg.parity, flg3_reg.aux,
                       flg3_reg.zero, flg3_reg.sign, psum3_reg, res3_reg};

    `include "assert_macros.svh"

    `ASSERT_IMPL(a_empty_out_ready, !m_tvalid, s_tready, "input stalled with empty output stage")
    `ASSERT_CLK(a_in_lands, (s_tvalid && s_tready) |=> v1_reg, "input transfer lost")
    `ASSERT_CLK(a_exec_moves, (v2_reg && !m_tvalid) |=> m_tvalid, "execute stage failed to advance")

endmodule

// ----- rtl/core/c8alu_exec.sv -----
// Execute logic of the ALU pipeline: result, pair sum, aux and carry flags.
// Depends on c8alu_pkg.
module c8alu_exec (
    input  c8alu_pkg::op_t   op,
    output c8alu_pkg::exec_t ex
);
    import c8alu_pkg::*;

    logic [7:0] addend;
    logic       cin;
    logic [8:0] sum9;
    logic [4:0] half5;
    logic       is_sub;
    logic [3:0] lo_nib;
    logic [3:0] hi_nib;
    logic       lo_fix;
    logic       hi_fix;
    logic [7:0] corr;
    logic [4:0] daa_half;
    logic [16:0] pair17;

    // Shared 8-bit adder for add, add with carry, subtract, subtract with borrow and compare
    always_comb
    begin
        is_sub = op.mode inside {MODE_SUB, MODE_SBB, MODE_CMP};
        addend = is_sub ? ~op.operand : op.operand;
        case (op.mode)
            MODE_ADC: cin = op.flags.carry;
            MODE_SUB: cin = 1'b1;
            MODE_SBB: cin = ~op.flags.carry;
            MODE_CMP: cin = 1'b1;
            default:  cin = 1'b0;
        endcase
        sum9  = {1'b0, op.acc} + {1'b0, addend} + {8'd0, cin};
        half5 = {1'b0, op.acc[3:0]} + {1'b0, addend[3:0]} + {4'd0, cin};
    end

    // Decimal adjust corrections
    always_comb
    begin
        lo_nib   = op.acc[3:0];
        hi_nib   = op.acc[7:4];
        lo_fix   = (lo_nib > BCD_MAX) || op.flags.aux;
        hi_fix   = (hi_nib > BCD_MAX) || op.flags.carry
                   || ((hi_nib >= BCD_MAX) && (lo_nib > BCD_MAX));
        corr     = (lo_fix ? DAA_LO_CORR : 8'h00) | (hi_fix ? DAA_HI_CORR : 8'h00);
        daa_half = {1'b0, lo_nib} + {1'b0, corr[3:0]};
    end

    assign pair17 = {1'b0, op.pair_base} + {1'b0, op.pair_addend};

    // Select result and flags by operation
    always_comb
    begin
        ex            = '0;
        ex.flags      = op.flags;
        case (op.mode)
            MODE_ADD, MODE_ADC:
            begin
                ex.result     = sum9[7:0];
                ex.flags.aux  = half5[4];
                ex.flags.carry = sum9[8];
                ex.write_back = 1'b1;
                ex.szp_upd    = 1'b1;
            end
            MODE_SUB, MODE_SBB, MODE_CMP:
            begin
                ex.result     = sum9[7:0];
                ex.flags.aux  = half5[4];
                ex.flags.carry = ~sum9[8];
                ex.write_back = (op.mode != MODE_CMP);
                ex.szp_upd    = 1'b1;
            end
            MODE_AND:
            begin
                ex.result     = op.acc & op.operand;
                ex.flags.aux  = op.acc[3] | op.operand[3];
                ex.flags.carry = 1'b0;
                ex.write_back = 1'b1;
                ex.szp_upd    = 1'b1;
            end
            MODE_XOR:
            begin
                ex.result     = op.acc ^ op.operand;
                ex.flags.aux  = 1'b0;
                ex.flags.carry = 1'b0;
                ex.write_back = 1'b1;
                ex.szp_upd    = 1'b1;
            end
            MODE_OR:
            begin
                ex.result     = op.acc | op.operand;
                ex.flags.aux  = 1'b0;
                ex.flags.carry = 1'b0;
                ex.write_back = 1'b1;
                ex.szp_upd    = 1'b1;
            end
            MODE_INC:
            begin
                ex.result     = op.operand + 8'd1;
                ex.flags.aux  = (op.operand[3:0] == 4'hF);
                ex.write_back = 1'b1;
                ex.szp_upd    = 1'b1;
            end
            MODE_DEC:
            begin
                ex.result     = op.operand - 8'd1;
                ex.flags.aux  = (op.operand[3:0] != 4'h0);
                ex.write_back = 1'b1;
                ex.szp_upd    = 1'b1;
            end
            MODE_DAA:
            begin
                ex.result     = op.acc + corr;
                ex.flags.aux  = daa_half[4];
                ex.flags.carry = op.flags.carry | hi_fix;
                ex.write_back = 1'b1;
                ex.szp_upd    = 1'b1;
            end
            MODE_RLC:
            begin
                ex.result     = {op.acc[6:0], op.acc[7]};
                ex.flags.carry = op.acc[7];
                ex.write_back = 1'b1;
            end
            MODE_RRC:
            begin
                ex.result     = {op.acc[0], op.acc[7:1]};
                ex.flags.carry = op.acc[0];
                ex.write_back = 1'b1;
            end
            MODE_RAL:
            begin
                ex.result     = {op.acc[6:0], op.flags.carry};
                ex.flags.carry = op.acc[7];
                ex.write_back = 1'b1;
            end
            MODE_RAR:
            begin
                ex.result     = {op.flags.carry, op.acc[7:1]};
                ex.flags.carry = op.acc[0];
                ex.write_back = 1'b1;
            end
            MODE_CMA:
            begin
                ex.result     = ~op.acc;
                ex.write_back = 1'b1;
            end
            MODE_STC:
            begin
                ex.flags.carry = 1'b1;
            end
            MODE_CMC:
            begin
                ex.flags.carry = ~op.flags.carry;
            end
            MODE_ADD16:
            begin
                ex.pair_sum   = pair17[15:0];
                ex.flags.carry = pair17[16];
                ex.write_back = 1'b1;
            end
            default:
            begin
                ex.flags = op.flags;
            end
        endcase
    end

endmodule

// ----- sim/cpu8_alu_with_bcd_flags_tb.sv -----
`timescale 1ns / 100ps
// Testbench for cpu8_alu_with_bcd_flags: directed and random ALU operations, with result
// and flag prediction and in-order checking of every output transfer.
// Depends on c8alu_pkg and the cpu8_alu_with_bcd_flags RTL.
module cpu8_alu_with_bcd_flags_tb;
    import c8alu_pkg::*;

    // Mode codes the block treats as no operation
    localparam logic [4:0] MODE_UNUSED_LO = 5'd19;
    localparam logic [4:0] MODE_UNUSED_HI = 5'd31;
    localparam int         STALL_LIMIT    = 1000;
    localparam int         RANDOM_OPS     = 800;
    localparam int         TAIL_CYCLES    = 10;

    // Predicted output of one operation
    typedef struct packed {
        logic [7:0]  result;
        logic [15:0] pair_sum;
        logic        write_back;
        flags_t      flags;
    } alu_out_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [55:0] s_tdata = '0;
    logic [4:0]  s_tuser = '0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [31:0] m_tdata;
    logic        m_tuser;

    alu_out_t    pending_results[$];
    int          fail_count = 0;
    int          quiet_cycles = 0;
    int          ready_hold = 0;
    bit          no_idle = 1'b0;

    cpu8_alu_with_bcd_flags dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

    // 10 ns clock
    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // Compute the result and new flags of one operation
    function automatic alu_out_t alu_compute(op_t q);
        logic [8:0]  sum9;
        logic [4:0]  nib;
        logic [7:0]  inv;
        logic        cin;
        logic [3:0]  lo;
        logic [3:0]  hi;
        logic [7:0]  corr;
        logic [16:0] sum17;
        logic        szp;
        alu_out_t    o;
        o.result     = '0;
        o.pair_sum   = '0;
        o.write_back = 1'b0;
        o.flags      = q.flags;
        szp          = 1'b0;
        case (q.mode)
            MODE_ADD, MODE_ADC:
            begin
                cin = (q.mode == MODE_ADC) ? q.flags.carry : 1'b0;
                sum9 = {1'b0, q.acc} + {1'b0, q.operand} + {8'd0, cin};
                nib = {1'b0, q.acc[3:0]} + {1'b0, q.operand[3:0]} + {4'd0, cin};
                o.flags.aux = nib[4];
                o.flags.carry = sum9[8];
                o.result = sum9[7:0];
                o.write_back = 1'b1;
                szp = 1'b1;
            end
            MODE_SUB, MODE_SBB, MODE_CMP:
            begin
                // subtract as add of the inverted operand; carry shows a borrow
                inv = ~q.operand;
                cin = (q.mode == MODE_SBB) ? ~q.flags.carry : 1'b1;
                sum9 = {1'b0, q.acc} + {1'b0, inv} + {8'd0, cin};
                nib = {1'b0, q.acc[3:0]} + {1'b0, inv[3:0]} + {4'd0, cin};
                o.flags.aux = nib[4];
                o.flags.carry = ~sum9[8];
                o.result = sum9[7:0];
                o.write_back = (q.mode != MODE_CMP);
                szp = 1'b1;
            end
            MODE_AND:
            begin
                o.result = q.acc & q.operand;
                o.flags.carry = 1'b0;
                o.flags.aux = q.acc[3] | q.operand[3];
                o.write_back = 1'b1;
                szp = 1'b1;
            end
            MODE_XOR, MODE_OR:
            begin
                o.result = (q.mode == MODE_XOR) ? (q.acc ^ q.operand) : (q.acc | q.operand);
                o.flags.carry = 1'b0;
                o.flags.aux = 1'b0;
                o.write_back = 1'b1;
                szp = 1'b1;
            end
            MODE_INC:
            begin
                o.result = q.operand + 8'd1;
                o.flags.aux = (q.operand[3:0] == 4'hF);
                o.write_back = 1'b1;
                szp = 1'b1;
            end
            MODE_DEC:
            begin
                o.result = q.operand - 8'd1;
                o.flags.aux = (q.operand[3:0] != 4'h0);
                o.write_back = 1'b1;
                szp = 1'b1;
            end
            MODE_DAA:
            begin
                lo = q.acc[3:0];
                hi = q.acc[7:4];
                corr = '0;
                if (lo > BCD_MAX || q.flags.aux)
                    corr = corr | DAA_LO_CORR;
                if (hi > BCD_MAX || q.flags.carry || (hi >= BCD_MAX && lo > BCD_MAX))
                begin
                    corr = corr | DAA_HI_CORR;
                    o.flags.carry = 1'b1;
                end
                nib = {1'b0, lo} + {1'b0, corr[3:0]};
                o.flags.aux = nib[4];
                o.result = q.acc + corr;
                o.write_back = 1'b1;
                szp = 1'b1;
            end
            MODE_RLC:
            begin
                o.flags.carry = q.acc[7];
                o.result = {q.acc[6:0], q.acc[7]};
                o.write_back = 1'b1;
            end
            MODE_RRC:
            begin
                o.flags.carry = q.acc[0];
                o.result = {q.acc[0], q.acc[7:1]};
                o.write_back = 1'b1;
            end
            MODE_RAL:
            begin
                o.flags.carry = q.acc[7];
                o.result = {q.acc[6:0], q.flags.carry};
                o.write_back = 1'b1;
            end
            MODE_RAR:
            begin
                o.flags.carry = q.acc[0];
                o.result = {q.flags.carry, q.acc[7:1]};
                o.write_back = 1'b1;
            end
            MODE_CMA:
            begin
                o.result = ~q.acc;
                o.write_back = 1'b1;
            end
            MODE_STC:
                o.flags.carry = 1'b1;
            MODE_CMC:
                o.flags.carry = ~q.flags.carry;
            MODE_ADD16:
            begin
                sum17 = {1'b0, q.pair_base} + {1'b0, q.pair_addend};
                o.flags.carry = sum17[16];
                o.pair_sum = sum17[15:0];
                o.write_back = 1'b1;
            end
            default:
            begin
            end
        endcase
        if (szp)
        begin
            o.flags.sign = o.result[7];
            o.flags.zero = (o.result == 8'h00);
            o.flags.parity = ~^o.result;
        end
        return o;
    endfunction

    // Build one operation; flags are given as {sign, zero, aux, parity, carry}
    function automatic op_t make_op(logic [4:0] mode, logic [7:0] acc, logic [7:0] operand,
                                    logic [15:0] base, logic [15:0] addend, flags_t f);
        op_t q;
        q.mode        = mode;
        q.acc         = acc;
        q.operand     = operand;
        q.pair_base   = base;
        q.pair_addend = addend;
        q.flags       = f;
        return q;
    endfunction

    // Draw an idle length: mostly none or short, now and then long
    function automatic int pick_gap();
        int roll;
        roll = int'($urandom_range(0, 99));
        if (no_idle || roll < 60)
            return 0;
        else if (roll < 95)
            return int'($urandom_range(1, 3));
        else
            return int'($urandom_range(10, 40));
    endfunction

    // Byte with a bias toward boundary and BCD values
    function automatic logic [7:0] pick_byte();
        logic [7:0] edges[12] = '{8'h00, 8'hFF, 8'h0F, 8'hF0, 8'h80, 8'h7F,
                                  8'h99, 8'h9A, 8'h01, 8'h09, 8'h0A, 8'hA0};
        if ($urandom_range(0, 3) == 0)
            return edges[$urandom_range(0, 11)];
        return 8'($urandom_range(0, 255));
    endfunction

    // Send one operation; called just after a falling edge, returns just after one
    task automatic issue_op(op_t q);
        int gap;
        gap = pick_gap();
        if (gap > 0)
        begin
            s_tvalid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= q.mode;
        s_tdata  <= {3'b000, q.flags.carry, q.flags.parity, q.flags.aux, q.flags.zero,
                     q.flags.sign, q.pair_addend, q.pair_base, q.operand, q.acc};
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
        pending_results.push_back(alu_compute(q));
        @(negedge clk);
    endtask

    // Hold off the sender until every pending result has come out
    task automatic drain_results();
        s_tvalid <= 1'b0;
        while (pending_results.size() != 0)
            @(posedge clk);
        @(negedge clk);
    endtask

    task automatic check_field(string name, logic [15:0] want, logic [15:0] got);
        if (want !== got)
        begin
            $error("%s: expected %0h, actual %0h", name, want, got);
            fail_count++;
        end
    endtask

    // Arithmetic corners: carries, borrows, compare, inc and dec wrap
    task automatic test_arith_corners();
        issue_op(make_op(MODE_ADD, 8'hFF, 8'h01, 16'h0000, 16'h0000, 5'b00000));
        issue_op(make_op(MODE_ADC, 8'h7F, 8'h00, 16'hFFFF, 16'hFFFF, 5'b00001));
        issue_op(make_op(MODE_SUB, 8'h00, 8'h01, 16'h0000, 16'h0000, 5'b11111));
        issue_op(make_op(MODE_SBB, 8'h80, 8'h7F, 16'h0000, 16'h0000, 5'b00001));
        issue_op(make_op(MODE_CMP, 8'h55, 8'h55, 16'h0000, 16'h0000, 5'b00000));
        issue_op(make_op(MODE_INC, 8'h00, 8'hFF, 16'h0000, 16'h0000, 5'b00001));
        issue_op(make_op(MODE_DEC, 8'hFF, 8'h00, 16'h0000, 16'h0000, 5'b00000));
        issue_op(make_op(MODE_DEC, 8'h00, 8'h10, 16'h0000, 16'h0000, 5'b11111));
    endtask

    // Logic operations, including aux carry from the OR of bit 3
    task automatic test_logic_ops();
        issue_op(make_op(MODE_AND, 8'hF0, 8'h0F, 16'h0000, 16'h0000, 5'b00001));
        issue_op(make_op(MODE_XOR, 8'hFF, 8'hFF, 16'h0000, 16'h0000, 5'b11111));
        issue_op(make_op(MODE_OR, 8'h00, 8'h00, 16'h0000, 16'h0000, 5'b11111));
    endtask

    // Decimal adjust, rotates, flag-only modes, pair add and unused codes
    task automatic test_special_modes();
        issue_op(make_op(MODE_DAA, 8'h9A, 8'h00, 16'h0000, 16'h0000, 5'b00000));
        issue_op(make_op(MODE_DAA, 8'h99, 8'h00, 16'h0000, 16'h0000, 5'b00100));
        issue_op(make_op(MODE_DAA, 8'h00, 8'h00, 16'h0000, 16'h0000, 5'b00001));
        issue_op(make_op(MODE_RLC, 8'h80, 8'h00, 16'h0000, 16'h0000, 5'b00000));
        issue_op(make_op(MODE_RRC, 8'h01, 8'h00, 16'h0000, 16'h0000, 5'b00000));
        issue_op(make_op(MODE_RAL, 8'h80, 8'h00, 16'h0000, 16'h0000, 5'b00000));
        issue_op(make_op(MODE_RAR, 8'h01, 8'h00, 16'h0000, 16'h0000, 5'b00001));
        issue_op(make_op(MODE_CMA, 8'h00, 8'hFF, 16'h0000, 16'h0000, 5'b10101));
        issue_op(make_op(MODE_STC, 8'hFF, 8'hFF, 16'hFFFF, 16'hFFFF, 5'b00000));
        issue_op(make_op(MODE_CMC, 8'hFF, 8'hFF, 16'hFFFF, 16'hFFFF, 5'b01010));
        issue_op(make_op(MODE_ADD16, 8'hFF, 8'hFF, 16'hFFFF, 16'h0001, 5'b00000));
        issue_op(make_op(MODE_ADD16, 8'h00, 8'h00, 16'h1234, 16'h4321, 5'b11111));
        issue_op(make_op(MODE_UNUSED_HI, 8'hFF, 8'hFF, 16'hFFFF, 16'hFFFF, 5'b11111));
    endtask

    // Random operations, with idle-free stretches and periodic full drains
    task automatic test_random_ops();
        op_t q;
        for (int i = 0; i < RANDOM_OPS; i++)
        begin
            no_idle = ((i % 150) < 30);
            if ($urandom_range(0, 9) == 0)
                q.mode = 5'($urandom_range(MODE_UNUSED_LO, MODE_UNUSED_HI));
            else
                q.mode = 5'($urandom_range(MODE_ADD, MODE_ADD16));
            q.acc         = pick_byte();
            q.operand     = pick_byte();
            q.pair_base   = 16'($urandom_range(0, 16'hFFFF));
            q.pair_addend = 16'($urandom_range(0, 16'hFFFF));
            q.flags       = 5'($urandom_range(0, 31));
            issue_op(q);
            if ((i % 200) == 199)
                drain_results();
        end
        no_idle = 1'b0;
    endtask

    // Output side: random back-pressure, released during idle-free stretches
    always @(negedge clk)
    begin
        if (!rst_n || no_idle)
        begin
            m_tready <= 1'b1;
        end
        else if (ready_hold > 0)
        begin
            m_tready <= 1'b0;
            ready_hold <= ready_hold - 1;
        end
        else
        begin : draw_stall
            int n;
            n = pick_gap();
            m_tready <= (n == 0);
            if (n > 0)
                ready_hold <= n - 1;
        end
    end

    // Compare each output transfer with the oldest pending result
    always @(posedge clk)
    begin : result_check
        alu_out_t want;
        if (rst_n && m_tvalid && m_tready)
        begin
            if (pending_results.size() == 0)
            begin
                $error("output transfer with no pending result: data %0h", m_tdata);
                fail_count++;
            end
            else
            begin
                want = pending_results.pop_front();
                check_field("result", 16'(want.result), 16'(m_tdata[7:0]));
                check_field("pair_sum", want.pair_sum, m_tdata[23:8]);
                check_field("write_back", 16'(want.write_back), 16'(m_tuser));
                check_field("sign_out", 16'(want.flags.sign), 16'(m_tdata[24]));
                check_field("zero_out", 16'(want.flags.zero), 16'(m_tdata[25]));
                check_field("aux_out", 16'(want.flags.aux), 16'(m_tdata[26]));
                check_field("parity_out", 16'(want.flags.parity), 16'(m_tdata[27]));
                check_field("carry_out", 16'(want.flags.carry), 16'(m_tdata[28]));
            end
        end
    end

    // Watchdog: end the run when no transfer happens for too long
    always @(posedge clk)
    begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= STALL_LIMIT)
        begin
            $error("no transfer for %0d cycles", STALL_LIMIT);
            $display("== FAIL ==");
            $finish;
        end
    end

    initial
    begin
        repeat (5) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);
        test_arith_corners();
        test_logic_ops();
        test_special_modes();
        drain_results();
        test_random_ops();
        drain_results();
        repeat (TAIL_CYCLES) @(posedge clk);
        if (fail_count == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

endmodule
